### src/ghst_pkg.sv
// ----------------------------------------------------------------------------
// ghst_pkg
// Shared types and constants of the generational handle slot table.
// ----------------------------------------------------------------------------
package ghst_pkg;

  localparam int SLOT_COUNT = 256;
  localparam int IDX_W      = 8;
  localparam int GEN_W      = 15;
  localparam int REF_W      = 16;
  localparam int PAY_W      = 32;
  localparam int CNT_W      = 9;

  localparam logic [REF_W-1:0] REF_MAX = 16'hFFFF;

  typedef enum logic [2:0] {
    KIND_ALLOC   = 3'd0,
    KIND_LOOKUP  = 3'd1,
    KIND_ADD_REF = 3'd2,
    KIND_RELEASE = 3'd3,
    KIND_COLLECT = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_EXEC,
    S_SCAN,
    S_COL_RES
  } state_t;

  // one slot word as kept in the slot memory
  typedef struct packed {
    logic             in_use;
    logic [GEN_W-1:0] gen;
    logic [REF_W-1:0] refs;
    logic [PAY_W-1:0] payload;
  } slot_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;    // latch input word, start reads
    logic fetch;     // read slot picked for allocate
    logic exec;      // finish op: write back, load result
    logic scan;      // one collect sweep step
    logic col_load;  // load collect result
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_done;
  } ctl_sts_t;

endpackage

### src/ghst_if.sv
// ----------------------------------------------------------------------------
// ghst_if
// Valid/ready channels for request words and result words.
// ----------------------------------------------------------------------------
interface ghst_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  handle_index;
  logic [14:0] handle_generation;
  logic [31:0] payload;

  modport source (output valid, kind, handle_index, handle_generation, payload,
                  input ready);
  modport sink   (input valid, kind, handle_index, handle_generation, payload,
                  output ready);
endinterface

interface ghst_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [7:0]  out_index;
  logic [14:0] out_generation;
  logic [31:0] out_payload;
  logic [15:0] out_ref_count;
  logic [8:0]  freed_count;

  modport source (output valid, status, out_index, out_generation, out_payload,
                  out_ref_count, freed_count, input ready);
  modport sink   (input valid, status, out_index, out_generation, out_payload,
                  out_ref_count, freed_count, output ready);
endinterface

### src/generational_handle_slot_table_unit.sv
// ----------------------------------------------------------------------------
// generational_handle_slot_table_unit
// Generational handle table with reference counts and a collect sweep.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries request words (kind, handle, payload); out_ch returns one
//   result word per request. A word moves when valid and ready are high.
//   Requests are worked one at a time; in_ch.ready is high while idle.
//   Each request reads its slot when accepted, then finishes in the exec
//   step; allocate first reads the FIFO head, then the picked slot, and
//   collect sweeps the grown slots, one slot read per cycle, before it
//   loads its result. The next request is taken at the earliest at the
//   edge where the result can first move.
//   Every op reads the single-port-read slot memory; ops that change a slot
//   write it back (read-modify-write), lookup and unknown kinds only read.
//   The result sits in an output register: a new request is taken while the
//   previous result waits; the finishing op holds until out_ch frees.
//   Reset (rst_n low, synchronous) empties the table: grown count and FIFO
//   pointers go to zero, so untouched slot entries are never read as valid.
// ----------------------------------------------------------------------------
module generational_handle_slot_table_unit
  import ghst_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  ghst_in_if.sink   in_ch,
  ghst_out_if.source out_ch
);

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  // sequencer: handshakes and op stepping
  ghst_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_kind  (in_ch.kind),
    .in_ready (in_ch.ready),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: slot memory, free FIFO, result register
  ghst_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_kind    (in_ch.kind),
    .in_index   (in_ch.handle_index),
    .in_gen     (in_ch.handle_generation),
    .in_payload (in_ch.payload),
    .res_status (out_ch.status),
    .res_index  (out_ch.out_index),
    .res_gen    (out_ch.out_generation),
    .res_payload(out_ch.out_payload),
    .res_refs   (out_ch.out_ref_count),
    .res_freed  (out_ch.freed_count)
  );

endmodule

### src/ghst_ctrl.sv
// ----------------------------------------------------------------------------
// ghst_ctrl
// Sequencer of the slot table: accepts words, steps ops, owns result valid.
// ----------------------------------------------------------------------------
module ghst_ctrl
  import ghst_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [2:0] in_kind,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  ctl_sts_t   sts,
  output ctl_cmd_t   cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;
  logic   load;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    load      = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (in_kind == KIND_ALLOC)        state_nxt = S_FETCH;
          else if (in_kind == KIND_COLLECT) state_nxt = S_SCAN;
          else                              state_nxt = S_EXEC;
        end
      end
      S_FETCH: begin
        cmd.fetch = 1'b1;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (out_free) begin
          cmd.exec  = 1'b1;
          load      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) state_nxt = S_COL_RES;
      end
      S_COL_RES: begin
        if (out_free) begin
          cmd.col_load = 1'b1;
          load         = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (load)           out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else                out_valid_nxt = out_valid_r;
  end

endmodule

### src/ghst_dp.sv
// ----------------------------------------------------------------------------
// ghst_dp
// Slot memory, free index FIFO, counters and result register.
// ----------------------------------------------------------------------------
module ghst_dp
  import ghst_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  ctl_cmd_t         cmd,
  output ctl_sts_t         sts,
  input  logic [2:0]       in_kind,
  input  logic [IDX_W-1:0] in_index,
  input  logic [GEN_W-1:0] in_gen,
  input  logic [PAY_W-1:0] in_payload,
  output logic [1:0]       res_status,
  output logic [IDX_W-1:0] res_index,
  output logic [GEN_W-1:0] res_gen,
  output logic [PAY_W-1:0] res_payload,
  output logic [REF_W-1:0] res_refs,
  output logic [CNT_W-1:0] res_freed
);

  localparam logic [CNT_W-1:0] SLOTS    = CNT_W'(SLOT_COUNT);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

  // memories
  slot_t            slot_mem [SLOT_COUNT];
  logic [IDX_W-1:0] q_mem    [SLOT_COUNT];

  slot_t            slot_rd_r;
  logic [IDX_W-1:0] q_rd_r;

  logic             slot_re, slot_we, q_we;
  logic [IDX_W-1:0] slot_ra, slot_wa;
  slot_t            slot_wd;

  // item latch
  logic [2:0]       kind_r;
  logic [IDX_W-1:0] idx_r;
  logic [GEN_W-1:0] gen_r;
  logic [PAY_W-1:0] pay_r;
  logic [IDX_W-1:0] slot_addr_r, slot_addr_nxt;

  // table state
  logic [CNT_W-1:0] grown_r, grown_nxt;
  logic [IDX_W-1:0] head_r, head_nxt;
  logic [IDX_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0] level_r, level_nxt;

  // collect sweep
  logic [CNT_W-1:0] scan_r, scan_nxt;
  logic             pend_r, pend_nxt;
  logic [IDX_W-1:0] pend_addr_r, pend_addr_nxt;
  logic [CNT_W-1:0] freed_r, freed_nxt;
  logic             scan_more;

  // op evaluation
  slot_t            cur;
  logic             hit;
  logic [GEN_W-1:0] old_gen, new_gen;
  logic [REF_W-1:0] refs_new;
  logic             pop, push;
  status_t          ex_status;
  logic [IDX_W-1:0] ex_index;
  logic [GEN_W-1:0] ex_gen;
  logic [PAY_W-1:0] ex_payload;
  logic [REF_W-1:0] ex_refs;
  logic             ex_we;
  slot_t            ex_wd;
  logic             grow;

  // result register
  logic [1:0]       status_r;
  logic [IDX_W-1:0] index_r;
  logic [GEN_W-1:0] res_gen_r;
  logic [PAY_W-1:0] payload_r;
  logic [REF_W-1:0] refs_r;
  logic [CNT_W-1:0] res_freed_r;

  assign cur       = slot_rd_r;
  assign scan_more = scan_r < grown_r;
  assign sts.scan_done = !scan_more && !pend_r;

  always_ff @(posedge clk) begin
    if (slot_we) slot_mem[slot_wa] <= slot_wd;
    if (slot_re) slot_rd_r <= slot_mem[slot_ra];
  end

  always_ff @(posedge clk) begin
    if (q_we) q_mem[tail_r] <= pend_addr_r;
    if (cmd.accept) q_rd_r <= q_mem[head_r];
  end

  // handle check against the word read for idx_r
  assign hit = (gen_r != '0) && ({1'b0, idx_r} < grown_r) && cur.in_use &&
               (cur.gen == gen_r);

  always_comb begin
    ex_status  = ST_INVALID;
    ex_index   = '0;
    ex_gen     = '0;
    ex_payload = '0;
    ex_refs    = '0;
    ex_we      = 1'b0;
    ex_wd      = cur;
    pop        = 1'b0;
    grow       = 1'b0;
    old_gen    = cur.gen;
    refs_new   = cur.refs;
    case (kind_r)
      KIND_ALLOC: begin
        if (level_r != '0) begin
          pop = 1'b1;
        end else if (grown_r < SLOTS) begin
          grow    = 1'b1;
          old_gen = '0;  // never touched before
        end
        if (pop || grow) begin
          ex_we      = 1'b1;
          ex_wd      = '{in_use: 1'b1, gen: new_gen, refs: '0, payload: pay_r};
          ex_status  = ST_OK;
          ex_index   = slot_addr_r;
          ex_gen     = new_gen;
          ex_payload = pay_r;
        end else begin
          ex_status = ST_FULL;
        end
      end
      KIND_LOOKUP, KIND_ADD_REF, KIND_RELEASE: begin
        if (hit) begin
          if (kind_r == KIND_ADD_REF && cur.refs != REF_MAX)
            refs_new = cur.refs + 1'b1;
          if (kind_r == KIND_RELEASE && cur.refs != '0)
            refs_new = cur.refs - 1'b1;
          ex_we      = (kind_r != KIND_LOOKUP);
          ex_wd.refs = refs_new;
          ex_status  = ST_OK;
          ex_index   = idx_r;
          ex_gen     = cur.gen;
          ex_payload = cur.payload;
          ex_refs    = refs_new;
        end
      end
      default: ex_status = ST_INVALID;
    endcase
  end

  always_comb begin
    new_gen = old_gen + 1'b1;
    if (new_gen == '0) new_gen = GEN_W'(1);
  end

  // memory port steering
  always_comb begin
    slot_re       = 1'b0;
    slot_ra       = in_index;
    slot_addr_nxt = slot_addr_r;
    scan_nxt      = scan_r;
    pend_nxt      = pend_r;
    pend_addr_nxt = pend_addr_r;
    if (cmd.accept) begin
      slot_re       = 1'b1;
      slot_addr_nxt = in_index;
      scan_nxt      = '0;
      pend_nxt      = 1'b0;
    end else if (cmd.fetch) begin
      slot_re       = 1'b1;
      slot_ra       = (level_r != '0) ? q_rd_r : grown_r[IDX_W-1:0];
      slot_addr_nxt = slot_ra;
    end else if (cmd.scan) begin
      slot_re       = scan_more;
      slot_ra       = scan_r[IDX_W-1:0];
      pend_nxt      = scan_more;
      pend_addr_nxt = scan_r[IDX_W-1:0];
      if (scan_more) scan_nxt = scan_r + 1'b1;
    end
  end

  // sweep evaluation: free slots in use with no references
  assign push = cmd.scan && pend_r && cur.in_use && (cur.refs == '0) &&
                (level_r < SLOTS);

  always_comb begin
    slot_we = 1'b0;
    slot_wa = slot_addr_r;
    slot_wd = ex_wd;
    if (cmd.exec) begin
      slot_we = ex_we;
    end else if (cmd.scan && pend_r && cur.in_use && (cur.refs == '0)) begin
      slot_we = 1'b1;
      slot_wa = pend_addr_r;
      slot_wd = '{in_use: 1'b0, gen: cur.gen + 1'b1, refs: cur.refs,
                  payload: cur.payload};
    end
  end

  assign q_we = push;

  always_comb begin
    grown_nxt = grown_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    level_nxt = level_r;
    freed_nxt = freed_r;
    if (cmd.accept) freed_nxt = '0;
    if (cmd.exec && pop) begin
      head_nxt  = (head_r == LAST_IDX) ? '0 : head_r + 1'b1;
      level_nxt = level_r - 1'b1;
    end
    if (cmd.exec && grow) grown_nxt = grown_r + 1'b1;
    if (cmd.scan && pend_r && cur.in_use && (cur.refs == '0))
      freed_nxt = freed_r + 1'b1;
    if (push) begin
      tail_nxt  = (tail_r == LAST_IDX) ? '0 : tail_r + 1'b1;
      level_nxt = level_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grown_r <= '0;
      head_r  <= '0;
      tail_r  <= '0;
      level_r <= '0;
      pend_r  <= 1'b0;
      scan_r  <= '0;
    end else begin
      grown_r <= grown_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      level_r <= level_nxt;
      pend_r  <= pend_nxt;
      scan_r  <= scan_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_addr_r <= slot_addr_nxt;
    pend_addr_r <= pend_addr_nxt;
    freed_r     <= freed_nxt;
    if (cmd.accept) begin
      kind_r <= in_kind;
      idx_r  <= in_index;
      gen_r  <= in_gen;
      pay_r  <= in_payload;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status_r    <= ex_status;
      index_r     <= ex_index;
      res_gen_r   <= ex_gen;
      payload_r   <= ex_payload;
      refs_r      <= ex_refs;
      res_freed_r <= '0;
    end else if (cmd.col_load) begin
      status_r    <= ST_OK;
      index_r     <= '0;
      res_gen_r   <= '0;
      payload_r   <= '0;
      refs_r      <= '0;
      res_freed_r <= freed_r;
    end
  end

  assign res_status  = status_r;
  assign res_index   = index_r;
  assign res_gen     = res_gen_r;
  assign res_payload = payload_r;
  assign res_refs    = refs_r;
  assign res_freed   = res_freed_r;

  // queued indices are distinct grown slots
  a_level_le_grown: assert property (@(posedge clk) disable iff (!rst_n)
    level_r <= grown_r)
    else $error("free FIFO holds more indices than grown slots");

  a_grown_bound: assert property (@(posedge clk) disable iff (!rst_n)
    grown_r <= SLOTS)
    else $error("grown count beyond table size");

  a_pend_follows_scan: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> ({1'b0, pend_addr_r} + 1'b1 == scan_r))
    else $error("sweep read pipeline out of step");

  a_no_pop_and_push: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.exec && push))
    else $error("FIFO pop and push in the same cycle");

endmodule

### sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the generational handle slot table. A scoreboard
// class tracks slot state, works out the result word of every accepted
// request and checks each returned word against it field by field.
// ----------------------------------------------------------------------------
module testbench
  import ghst_pkg::*;
();

  localparam logic [GEN_W-1:0] GEN_MAX           = '1;
  localparam logic [2:0]       KIND_TOP          = '1;   // highest kind code
  localparam logic [2:0]       KIND_FIRST_UNUSED = 3'(KIND_COLLECT + 1);
  localparam int               RANDOM_WORDS      = 400;
  localparam int               TAIL_WORDS        = 80;   // final stretch, no idling
  localparam int               SETTLE_CYCLES     = SLOT_COUNT + 16;
  localparam int               CYCLE_LIMIT       = 1_000_000;
  localparam int               MAX_REPORTS       = 30;

  typedef struct packed {
    logic [2:0]       kind;
    logic [IDX_W-1:0] handle_index;
    logic [GEN_W-1:0] handle_generation;
    logic [PAY_W-1:0] payload;
  } request_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [IDX_W-1:0] out_index;
    logic [GEN_W-1:0] out_generation;
    logic [PAY_W-1:0] out_payload;
    logic [REF_W-1:0] out_ref_count;
    logic [CNT_W-1:0] freed_count;
  } result_t;

  // --------------------------------------------------------------------------
  // Scoreboard: own copy of the slot table plus the queue of result words
  // still owed by the block.
  // --------------------------------------------------------------------------
  class slot_table_scoreboard;
    bit               live[SLOT_COUNT];
    bit [GEN_W-1:0]   gen[SLOT_COUNT];
    bit [REF_W-1:0]   refs[SLOT_COUNT];
    bit [PAY_W-1:0]   pay[SLOT_COUNT];
    int unsigned      grown;
    bit [IDX_W-1:0]   free_fifo[$];
    result_t          owed[$];
    int               last_alloc_slot;
    int unsigned      errors;
    int unsigned      n_kind[8];
    int unsigned      n_status[4];
    int unsigned      n_freed;
    int unsigned      n_saturated;

    function bit handle_valid(bit [IDX_W-1:0] idx, bit [GEN_W-1:0] g);
      return g != 0 && idx < grown && live[idx] && gen[idx] == g;
    endfunction

    function result_t slot_view(int s);
      result_t r;
      r                = '0;
      r.status         = ST_OK;
      r.out_index      = IDX_W'(s);
      r.out_generation = gen[s];
      r.out_payload    = pay[s];
      r.out_ref_count  = refs[s];
      return r;
    endfunction

    function int random_live_slot();
      int cand[$];
      int i;
      for (i = 0; i < SLOT_COUNT; i++)
        if (live[i]) cand.insert(cand.size(), i);
      if (cand.size() == 0) return -1;
      return cand[$urandom_range(0, cand.size() - 1)];
    endfunction

    // work out the result of one accepted request and advance the table
    function void note_request(request_t rq);
      result_t     r;
      int          s;
      int          i;
      int unsigned freed;
      r = '0;
      n_kind[rq.kind]++;
      case (rq.kind)
        KIND_ALLOC: begin
          if (free_fifo.size() > 0) begin
            s = free_fifo.pop_front();
          end else if (grown < SLOT_COUNT) begin
            s = grown;
            grown++;
          end else begin
            s = -1;
          end
          if (s < 0) begin
            r.status = ST_FULL;
          end else begin
            pay[s]  = rq.payload;
            refs[s] = '0;
            gen[s]  = gen[s] + 1'b1;
            if (gen[s] == 0) gen[s] = 1;   // generation 0 is reserved
            live[s] = 1'b1;
            last_alloc_slot = s;
            r = slot_view(s);
          end
        end
        KIND_LOOKUP, KIND_ADD_REF, KIND_RELEASE: begin
          if (!handle_valid(rq.handle_index, rq.handle_generation)) begin
            r.status = ST_INVALID;
          end else begin
            s = rq.handle_index;
            if (rq.kind == KIND_ADD_REF) begin
              if (refs[s] != REF_MAX) refs[s]++;
              else n_saturated++;
            end
            if (rq.kind == KIND_RELEASE && refs[s] != 0) refs[s]--;
            r = slot_view(s);
          end
        end
        KIND_COLLECT: begin
          freed = 0;
          for (i = 0; i < grown; i++) begin
            if (live[i] && refs[i] == 0) begin
              live[i] = 1'b0;
              gen[i]  = gen[i] + 1'b1;   // no skip of 0 here
              if (free_fifo.size() < SLOT_COUNT)
                free_fifo.insert(free_fifo.size(), IDX_W'(i));
              freed++;
            end
          end
          n_freed += freed;
          r.freed_count = CNT_W'(freed);
        end
        default: r.status = ST_INVALID;
      endcase
      n_status[r.status]++;
      owed.insert(owed.size(), r);
    endfunction

    function void compare_field(string what, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      end
    endfunction

    function void check_result(result_t act);
      result_t want;
      if (owed.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: result word with none expected, actual %0h", $time, act);
        return;
      end
      want = owed.pop_front();
      compare_field("status",         want.status,         act.status);
      compare_field("out_index",      want.out_index,      act.out_index);
      compare_field("out_generation", want.out_generation, act.out_generation);
      compare_field("out_payload",    want.out_payload,    act.out_payload);
      compare_field("out_ref_count",  want.out_ref_count,  act.out_ref_count);
      compare_field("freed_count",    want.freed_count,    act.freed_count);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels, block
  // --------------------------------------------------------------------------
  logic clk;
  logic rst_n;
  bit   no_idling;     // set: neither side idles
  int   stall_left;
  int   cycle_count;

  ghst_in_if  in_ch();
  ghst_out_if out_ch();

  slot_table_scoreboard sb = new();

  generational_handle_slot_table_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // result side: stalls in random bursts, ready otherwise
  initial out_ch.ready = 1'b0;
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else if (!no_idling && rst_n && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 14) - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // every result word that moves is checked against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready)
      sb.check_result('{status:         out_ch.status,
                        out_index:      out_ch.out_index,
                        out_generation: out_ch.out_generation,
                        out_payload:    out_ch.out_payload,
                        out_ref_count:  out_ch.out_ref_count,
                        freed_count:    out_ch.freed_count});
  end

  // hard stop if the block hangs
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------

  // Drive one request word; returns at the edge where it is taken. Valid
  // stays high afterwards so the next call can go back to back.
  task automatic send_word(logic [2:0] kind, logic [IDX_W-1:0] idx,
                           logic [GEN_W-1:0] g, logic [PAY_W-1:0] p);
    request_t rq;
    int       gap;
    rq = '{kind: kind, handle_index: idx, handle_generation: g, payload: p};
    if (!no_idling && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid             <= 1'b1;
    in_ch.kind              <= rq.kind;
    in_ch.handle_index      <= rq.handle_index;
    in_ch.handle_generation <= rq.handle_generation;
    in_ch.payload           <= rq.payload;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sb.note_request(rq);
  endtask

  // handle fields random; used for allocate, collect and unknown kinds
  task automatic send_bare(logic [2:0] kind);
    send_word(kind, IDX_W'($urandom_range(0, SLOT_COUNT - 1)),
              GEN_W'($urandom_range(0, GEN_MAX)), $urandom());
  endtask

  // sender holds off until every owed result has come back
  task automatic drain_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    int               n;
    int               s;
    int               roll;
    logic [2:0]       kind_sel;
    logic [IDX_W-1:0] idx;
    logic [GEN_W-1:0] g;

    rst_n                   = 1'b0;
    in_ch.valid             = 1'b0;
    in_ch.kind              = KIND_ALLOC;
    in_ch.handle_index      = '0;
    in_ch.handle_generation = '0;
    in_ch.payload           = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // empty table: any handle is out of range, collect frees nothing
    send_word(KIND_LOOKUP, '0, GEN_W'(1), '0);
    send_bare(KIND_COLLECT);

    // directed: slot 0 through one life, then reuse and growth
    send_bare(KIND_ALLOC);                                 // grow into slot 0
    send_word(KIND_LOOKUP,  '0, GEN_W'(1), '0);
    send_word(KIND_ADD_REF, '0, GEN_W'(1), '0);
    send_word(KIND_RELEASE, '0, GEN_W'(1), '0);
    send_word(KIND_RELEASE, '0, GEN_W'(1), '0);            // release at zero
    send_bare(KIND_COLLECT);                               // frees slot 0
    send_word(KIND_LOOKUP,  '0, GEN_W'(1), '0);            // stale handle
    send_word(KIND_LOOKUP,  '0, '0, '0);                   // generation zero
    send_word(KIND_ALLOC, IDX_W'(SLOT_COUNT - 1), GEN_MAX, '0);  // reuse slot 0
    send_word(KIND_ALLOC, '0, '0, '1);                     // grow into slot 1
    send_word(KIND_LOOKUP, IDX_W'(1), GEN_W'(1), '0);
    send_word(KIND_LOOKUP, IDX_W'(1), GEN_W'(2), '0);      // generation differs
    send_word(KIND_LOOKUP, IDX_W'(2), GEN_W'(1), '0);      // index not grown yet
    send_word(KIND_LOOKUP, IDX_W'(SLOT_COUNT - 1), GEN_MAX, '1);
    send_bare(KIND_FIRST_UNUSED);                          // unknown kinds
    send_bare(KIND_TOP - 3'd1);
    send_bare(KIND_TOP);
    send_word(KIND_ADD_REF, IDX_W'(1), GEN_W'(1), '0);
    send_bare(KIND_COLLECT);                               // frees slot 0 only
    send_word(KIND_LOOKUP, '0, sb.gen[0], '0);             // free slot, same generation
    send_word(KIND_RELEASE, IDX_W'(1), GEN_W'(1), '0);
    send_bare(KIND_ALLOC);                                 // oldest freed index
    drain_results();

    // fill every slot, holding a reference on some, then hit the full case
    while (sb.free_fifo.size() != 0 || sb.grown < SLOT_COUNT) begin
      send_bare(KIND_ALLOC);
      if ($urandom_range(0, 3) == 0) begin
        s = sb.last_alloc_slot;
        send_word(KIND_ADD_REF, IDX_W'(s), sb.gen[s], $urandom());
      end
    end
    send_bare(KIND_ALLOC);
    send_bare(KIND_ALLOC);
    drain_results();

    // Random traffic: mostly live handles, then broken handles and noise.
    for (n = 0; n < RANDOM_WORDS; n++) begin
      if (n == RANDOM_WORDS / 2) drain_results();
      no_idling = (n >= RANDOM_WORDS - TAIL_WORDS);
      roll = $urandom_range(0, 99);
      s    = sb.random_live_slot();
      if (roll < 20) begin
        send_bare(KIND_ALLOC);
      end else if (roll < 70 && s >= 0) begin
        kind_sel = (roll < 35) ? KIND_LOOKUP : (roll < 55) ? KIND_ADD_REF : KIND_RELEASE;
        send_word(kind_sel, IDX_W'(s), sb.gen[s], $urandom());
      end else if (roll < 85) begin
        kind_sel = 3'($urandom_range(KIND_LOOKUP, KIND_RELEASE));
        case ($urandom_range(0, 2))
          0: begin
            idx = IDX_W'($urandom_range(0, SLOT_COUNT - 1));
            g   = GEN_W'($urandom_range(0, GEN_MAX));
          end
          1: begin   // live index, wrong generation
            idx = (s >= 0) ? IDX_W'(s) : IDX_W'($urandom_range(0, SLOT_COUNT - 1));
            g   = sb.gen[idx] ^ GEN_W'($urandom_range(1, GEN_MAX));
          end
          default: begin   // stored generation of any slot, mostly free ones
            idx = IDX_W'($urandom_range(0, SLOT_COUNT - 1));
            g   = sb.gen[idx];
          end
        endcase
        send_word(kind_sel, idx, g, $urandom());
      end else if (roll < 94) begin
        send_bare(KIND_COLLECT);
      end else begin
        send_bare(3'($urandom_range(KIND_FIRST_UNUSED, KIND_TOP)));
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Requests: %0d allocate, %0d lookup, %0d add-ref, %0d release, %0d collect, %0d other",
             sb.n_kind[KIND_ALLOC], sb.n_kind[KIND_LOOKUP], sb.n_kind[KIND_ADD_REF],
             sb.n_kind[KIND_RELEASE], sb.n_kind[KIND_COLLECT],
             sb.n_kind[5] + sb.n_kind[6] + sb.n_kind[7]);
    $display("Results: %0d ok, %0d bad handle, %0d full; %0d slots swept, %0d saturated adds",
             sb.n_status[ST_OK], sb.n_status[ST_INVALID], sb.n_status[ST_FULL],
             sb.n_freed, sb.n_saturated);
    if (sb.errors == 0 && sb.owed.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

### generational_handle_slot_table_unit.f
src/ghst_pkg.sv
src/ghst_if.sv
src/ghst_ctrl.sv
src/ghst_dp.sv
src/generational_handle_slot_table_unit.sv
sim/testbench.sv
